// ===== src/wfcc_pkg.sv =====
package wfcc_pkg;

  localparam int unsigned LogDepthDefault = 32;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned CountW   = 32;
  localparam int unsigned LogSlotW = 5;

  localparam logic [1:0]  KindMgmt     = 2'd0;
  localparam logic [1:0]  KindData     = 2'd1;

  localparam logic [3:0]  SubProbeReq  = 4'h4;
  localparam logic [3:0]  SubProbeResp = 4'h5;
  localparam logic [3:0]  SubBeacon    = 4'h8;
  localparam logic [3:0]  SubDisassoc  = 4'hA;
  localparam logic [3:0]  SubDeauth    = 4'hC;

  localparam logic [11:0] MinFilterLen = 12'd16;
  localparam logic [2:0]  PhaseLast    = 3'd4;

  typedef enum logic {
    CfgFilterEnable = 1'b0,
    CfgOwnAddress   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ClsOther  = 3'd0,
    ClsData   = 3'd1,
    ClsDeauth = 3'd2,
    ClsBeacon = 3'd3,
    ClsProbe  = 3'd4
  } pkt_class_e;

  typedef struct packed {
    logic [1:0]        frame_kind;
    logic [7:0]        frame_control;
    logic [11:0]       frame_length;
    logic signed [7:0] signal_strength;
    logic [3:0]        radio_channel;
    logic [AddrW-1:0]  receiver_address;
    logic [AddrW-1:0]  transmitter_address;
  } frame_t;

  typedef struct packed {
    logic                     dropped;
    pkt_class_e               packet_class;
    logic [3:0]               subtype;
    logic                     log_sample;
    logic [LogSlotW-1:0]      log_slot;
    logic [CountW-1:0]        total_count;
    logic [CountW-1:0]        beacon_count;
    logic [CountW-1:0]        data_count;
    logic [CountW-1:0]        deauth_count;
    logic [CountW-1:0]        probe_count;
    logic signed [CountW-1:0] rssi_sum;
    logic [3:0]               last_deauth_channel;
  } result_t;

  typedef struct packed {
    logic             filter_enable;
    logic [AddrW-1:0] own_address;
  } cfg_t;

endpackage

// ===== src/wfcc_if.sv =====
interface wfcc_in_if;
  logic            valid;
  logic            ready;
  wfcc_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wfcc_out_if;
  logic             valid;
  logic             ready;
  wfcc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wfcc_stats.sv =====
module wfcc_stats import wfcc_pkg::*; #(
  parameter int unsigned LogDepth = LogDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    upd_i,
  input  cfg_t    cfg_i,
  input  frame_t  item_i,
  output result_t result_o
);

  localparam int unsigned SlotW = $clog2(LogDepth);

  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] beacon_q, beacon_d;
  logic [CountW-1:0] data_q, data_d;
  logic [CountW-1:0] deauth_q, deauth_d;
  logic [CountW-1:0] probe_q, probe_d;
  logic [CountW-1:0] sum_q, sum_d;
  logic [2:0]        phase_q, phase_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [3:0]        chan_q, chan_d;

  logic                      drop;
  logic                      sample;
  logic [3:0]                sub;
  pkt_class_e                cls;
  logic [SlotW+LogSlotW-1:0] slot_ext;

  assign drop = cfg_i.filter_enable && (cfg_i.own_address[AddrW-1 -: 8] != 8'd0) &&
                (item_i.frame_length >= MinFilterLen) &&
                ((item_i.receiver_address == cfg_i.own_address) ||
                 (item_i.transmitter_address == cfg_i.own_address));

  always_comb begin
    sub = 4'd0;
    cls = ClsOther;
    unique case (item_i.frame_kind)
      KindMgmt: begin
        sub = item_i.frame_control[7:4];
        unique case (item_i.frame_control[7:4])
          SubBeacon:                 cls = ClsBeacon;
          SubProbeReq, SubProbeResp: cls = ClsProbe;
          SubDeauth, SubDisassoc:    cls = ClsDeauth;
          default:                   cls = ClsOther;
        endcase
      end
      KindData: cls = ClsData;
      default:  cls = ClsOther;
    endcase
  end

  always_comb begin
    total_d  = total_q;
    beacon_d = beacon_q;
    data_d   = data_q;
    deauth_d = deauth_q;
    probe_d  = probe_q;
    sum_d    = sum_q;
    phase_d  = phase_q;
    slot_d   = slot_q;
    chan_d   = chan_q;
    sample   = 1'b0;
    if (!drop) begin
      total_d = total_q + CountW'(1);
      sum_d   = sum_q + {{(CountW-8){item_i.signal_strength[7]}}, item_i.signal_strength};
      unique case (cls)
        ClsBeacon: beacon_d = beacon_q + CountW'(1);
        ClsProbe:  probe_d  = probe_q + CountW'(1);
        ClsDeauth: begin
          deauth_d = deauth_q + CountW'(1);
          chan_d   = item_i.radio_channel;
        end
        ClsData:   data_d = data_q + CountW'(1);
        default: ;
      endcase
      phase_d = (phase_q >= PhaseLast) ? 3'd0 : phase_q + 3'd1;
      if (phase_d == 3'd0) begin
        sample = 1'b1;
        slot_d = (slot_q == SlotW'(LogDepth - 1)) ? '0 : slot_q + SlotW'(1);
      end
    end
  end

  assign slot_ext = {{LogSlotW{1'b0}}, slot_q};

  always_comb begin
    result_o.dropped             = drop;
    result_o.packet_class        = drop ? ClsOther : cls;
    result_o.subtype             = drop ? 4'd0 : sub;
    result_o.log_sample          = sample;
    result_o.log_slot            = slot_ext[LogSlotW-1:0];
    result_o.total_count         = total_d;
    result_o.beacon_count        = beacon_d;
    result_o.data_count          = data_d;
    result_o.deauth_count        = deauth_d;
    result_o.probe_count         = probe_d;
    result_o.rssi_sum            = sum_d;
    result_o.last_deauth_channel = chan_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      beacon_q <= '0;
      data_q   <= '0;
      deauth_q <= '0;
      probe_q  <= '0;
      sum_q    <= '0;
      phase_q  <= '0;
      slot_q   <= '0;
      chan_q   <= '0;
    end else if (upd_i) begin
      total_q  <= total_d;
      beacon_q <= beacon_d;
      data_q   <= data_d;
      deauth_q <= deauth_d;
      probe_q  <= probe_d;
      sum_q    <= sum_d;
      phase_q  <= phase_d;
      slot_q   <= slot_d;
      chan_q   <= chan_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast) else $error("sample phase out of range");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotW'(LogDepth - 1)) else $error("ring slot out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !drop |=> total_q == $past(total_q) + CountW'(1))
    else $error("total count did not advance");

  a_drop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && drop |=> $stable(total_q) && $stable(sum_q) && $stable(phase_q) &&
                      $stable(slot_q))
    else $error("dropped word changed state");
`endif

endmodule

// ===== src/wireless_frame_classify_counter_top.sv =====
// frame classifier and counter
// frame_i carries one received-frame summary per word (valid/ready); result_o
// returns one result word per accepted frame, in order, with the class,
// the sample flag, the log slot and all counters after that frame.
// configuration: cfg_we_i writes cfg_wdata_i into the register selected by
// cfg_idx_i (0 filter enable, 1 own address); write only while idle.
// datapath: an accepted frame is held in the input register, and the counter
// update moves it from there into the result register that drives result_o.
// throughput: one frame per cycle while result_o.ready stays high, set by the
// combinational counter update between the input and the result register.
// stall: when result_o.ready is low the result word holds; the input
// register still takes one more frame, then frame_i.ready drops.
// reset: rst_ni clears counters, sample phase, log slot, deauth channel,
// configuration and both valid flags.
module wireless_frame_classify_counter_top import wfcc_pkg::*; #(
  parameter int unsigned LogDepth = LogDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  wfcc_in_if.sink          frame_i,
  wfcc_out_if.source       result_o
);

  cfg_t    cfg_q;
  logic    in_valid_q, in_valid_d;
  frame_t  in_data_q;
  logic    out_valid_q, out_valid_d;
  result_t out_data_q;
  result_t stats_res;
  logic    out_free;
  logic    advance;
  logic    accept;

  assign out_free      = !out_valid_q || result_o.ready;
  assign advance       = in_valid_q && out_free;
  assign frame_i.ready = !in_valid_q || out_free;
  assign accept        = frame_i.valid && frame_i.ready;

  assign in_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  wfcc_stats #(
    .LogDepth (LogDepth)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (advance),
    .cfg_i    (cfg_q),
    .item_i   (in_data_q),
    .result_o (stats_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFilterEnable: cfg_q.filter_enable <= cfg_wdata_i[0];
        CfgOwnAddress:   cfg_q.own_address   <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= frame_i.data;
    end
    if (advance) begin
      out_data_q <= stats_res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wfcc_pkg::*;

  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned DrainCycles   = 4;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [AddrW-1:0] cfg_wdata;

  wfcc_in_if  frame_bus ();
  wfcc_out_if result_bus ();

  wireless_frame_classify_counter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .frame_i     (frame_bus),
    .result_o    (result_bus)
  );

  frame_t  pending_frames[$];
  result_t expected_results[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_asked;
  int      hold_off_served;
  int      hold_off_left;
  logic    frame_moved;

  // configuration copy seen by the predictor
  logic             filter_en_cfg;
  logic [AddrW-1:0] own_addr_cfg;

  // classifier state
  logic [CountW-1:0]        frames_seen;
  logic [CountW-1:0]        beacons_seen;
  logic [CountW-1:0]        data_seen;
  logic [CountW-1:0]        deauths_seen;
  logic [CountW-1:0]        probes_seen;
  logic signed [CountW-1:0] strength_total;
  logic [2:0]               phase5;
  logic [LogSlotW-1:0]      slot_now;
  logic [3:0]               deauth_chan;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic predict_result(input frame_t f, output result_t r);
    logic own_hit;
    r = '0;
    own_hit = (f.receiver_address == own_addr_cfg) || (f.transmitter_address == own_addr_cfg);
    if (filter_en_cfg && own_addr_cfg[AddrW-1 -: 8] != 8'd0 &&
        f.frame_length >= MinFilterLen && own_hit) begin
      r.dropped  = 1'b1;
      r.log_slot = slot_now;
    end else begin
      frames_seen    += 1;
      strength_total += {{24{f.signal_strength[7]}}, f.signal_strength};
      if (f.frame_kind == KindMgmt) begin
        r.subtype = f.frame_control[7:4];
        case (r.subtype)
          SubBeacon: begin
            beacons_seen += 1;
            r.packet_class = ClsBeacon;
          end
          SubProbeReq, SubProbeResp: begin
            probes_seen += 1;
            r.packet_class = ClsProbe;
          end
          SubDeauth, SubDisassoc: begin
            deauths_seen += 1;
            deauth_chan = f.radio_channel;
            r.packet_class = ClsDeauth;
          end
          default: r.packet_class = ClsOther;
        endcase
      end else if (f.frame_kind == KindData) begin
        data_seen += 1;
        r.packet_class = ClsData;
      end else begin
        r.packet_class = ClsOther;
      end
      phase5     = (phase5 >= PhaseLast) ? 3'd0 : phase5 + 3'd1;
      r.log_slot = slot_now;
      if (phase5 == 3'd0) begin
        r.log_sample = 1'b1;
        slot_now = LogSlotW'((int'(slot_now) + 1) % LogDepthDefault);
      end
    end
    r.total_count         = frames_seen;
    r.beacon_count        = beacons_seen;
    r.data_count          = data_seen;
    r.deauth_count        = deauths_seen;
    r.probe_count         = probes_seen;
    r.rssi_sum            = strength_total;
    r.last_deauth_channel = deauth_chan;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // driver: a word stays on the bus until it is taken
  always @(negedge clk_i) begin
    frame_t next_frame;
    if (!rst_ni) begin
      frame_bus.valid <= 1'b0;
    end else if (!frame_bus.valid || frame_moved) begin
      if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_frame = pending_frames.pop_front();
        frame_bus.data  <= next_frame;
        frame_bus.valid <= 1'b1;
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      result_bus.ready <= 1'b0;
      hold_off_left    <= hold_off_left - 1;
    end else if (hold_off_served < hold_off_asked) begin
      result_bus.ready <= 1'b0;
      hold_off_left    <= HoldOffCycles;
      hold_off_served  <= hold_off_served + 1;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    frame_moved <= frame_bus.valid && frame_bus.ready;
    if (rst_ni) begin
      if (frame_bus.valid && frame_bus.ready) begin
        predict_result(frame_bus.data, want);
        expected_results.push_back(want);
      end
      if (result_bus.valid && result_bus.ready) begin
        got = result_bus.data;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word: expected none, actual %0h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("dropped", want.dropped, got.dropped);
          check_field("packet_class", want.packet_class, got.packet_class);
          check_field("subtype", want.subtype, got.subtype);
          check_field("log_sample", want.log_sample, got.log_sample);
          check_field("log_slot", want.log_slot, got.log_slot);
          check_field("total_count", want.total_count, got.total_count);
          check_field("beacon_count", want.beacon_count, got.beacon_count);
          check_field("data_count", want.data_count, got.data_count);
          check_field("deauth_count", want.deauth_count, got.deauth_count);
          check_field("probe_count", want.probe_count, got.probe_count);
          check_field("rssi_sum", want.rssi_sum, got.rssi_sum);
          check_field("last_deauth_channel", want.last_deauth_channel,
                      got.last_deauth_channel);
        end
      end
    end
  end

  function automatic frame_t make_frame(logic [1:0] kind, logic [7:0] fc, logic [11:0] len,
                                        logic [7:0] rssi, logic [3:0] chan,
                                        logic [AddrW-1:0] ra, logic [AddrW-1:0] ta);
    frame_t f;
    f.frame_kind          = kind;
    f.frame_control       = fc;
    f.frame_length        = len;
    f.signal_strength     = rssi;
    f.radio_channel       = chan;
    f.receiver_address    = ra;
    f.transmitter_address = ta;
    return f;
  endfunction

  function automatic logic [AddrW-1:0] random_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic frame_t random_frame();
    frame_t     f;
    int         pick;
    logic [3:0] known_subs[5];
    known_subs = '{SubProbeReq, SubProbeResp, SubBeacon, SubDisassoc, SubDeauth};
    pick = $urandom_range(9);
    f.frame_kind = (pick < 5) ? KindMgmt : (pick < 8) ? KindData : 2'($urandom_range(2, 3));
    f.frame_control = 8'($urandom);
    if (f.frame_kind == KindMgmt && $urandom_range(9) < 7)
      f.frame_control[7:4] = known_subs[$urandom_range(4)];
    pick = $urandom_range(9);
    if (pick < 2)
      f.frame_length = 12'($urandom_range(14, 17));
    else if (pick == 2)
      f.frame_length = $urandom_range(1) ? 12'hFFF : 12'h000;
    else
      f.frame_length = 12'($urandom);
    f.signal_strength     = 8'($urandom);
    f.radio_channel       = 4'($urandom);
    f.receiver_address    = random_addr();
    f.transmitter_address = random_addr();
    pick = $urandom_range(19);
    if (pick < 5)
      f.receiver_address = own_addr_cfg;
    else if (pick < 8)
      f.transmitter_address = own_addr_cfg;
    return f;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [AddrW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgFilterEnable)
      filter_en_cfg = value[0];
    else
      own_addr_cfg = value;
  endtask

  // checked after the rising edge has settled, away from the driver's edge
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_frames.size() > 0 || frame_bus.valid || expected_results.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_random(int count, int send_pct, int stall_pct, bit hold_off);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_frames.push_back(random_frame());
    if (hold_off) hold_off_asked++;
    wait_idle();
  endtask

  initial begin
    logic [AddrW-1:0] own;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgFilterEnable;
    cfg_wdata        = '0;
    frame_bus.valid  = 1'b0;
    frame_bus.data   = '0;
    result_bus.ready = 1'b0;
    frame_moved      = 1'b0;
    error_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_asked   = 0;
    hold_off_served  = 0;
    hold_off_left    = 0;
    filter_en_cfg    = 1'b0;
    own_addr_cfg     = '0;
    frames_seen      = '0;
    beacons_seen     = '0;
    data_seen        = '0;
    deauths_seen     = '0;
    probes_seen      = '0;
    strength_total   = '0;
    phase5           = '0;
    slot_now         = '0;
    deauth_chan      = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words
    own = 48'hA1B2C3D4E5F6;
    write_reg(CfgFilterEnable, 48'd1);
    write_reg(CfgOwnAddress, own);
    pending_frames.push_back(make_frame(KindMgmt, 8'h80, 12'd100, 8'h80, 4'd14,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h40, 12'd60, 8'h7F, 4'd1,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h5A, 12'd60, 8'hC4, 4'd2,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'hC0, 12'd26, 8'hD0, 4'd6,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'hA3, 12'd26, 8'hB0, 4'd15,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h00, 12'd40, 8'h00, 4'd3,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'hF0, 12'd40, 8'hFF, 4'd0,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'hB1, 12'd40, 8'h01, 4'd9,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindData, 8'hFF, 12'd1500, 8'hE0, 4'd11,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(2'd2, 8'h80, 12'd30, 8'hA0, 4'd7,
                                        random_addr(), random_addr()));
    // kind 3 counts as other even with a beacon subtype
    pending_frames.push_back(make_frame(2'd3, 8'h80, 12'd30, 8'h10, 4'd5,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindData, 8'h08, 12'd16, 8'hC8, 4'd1,
                                        own, random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'hC0, 12'hFFF, 8'hC8, 4'd2,
                                        random_addr(), own));
    pending_frames.push_back(make_frame(KindMgmt, 8'h80, 12'd15, 8'hC8, 4'd4,
                                        own, own));
    pending_frames.push_back(make_frame(KindData, 8'h08, 12'd0, 8'h80, 4'd8,
                                        own, random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h8F, 12'd0, 8'h7F, 4'd10,
                                        48'h0, 48'hFFFFFFFFFFFF));
    pending_frames.push_back(make_frame(KindData, 8'h88, 12'd2000, 8'h80, 4'd12,
                                        48'hFFFFFFFFFFFF, 48'h0));
    pending_frames.push_back(make_frame(KindMgmt, 8'hC5, 12'd20, 8'h9C, 4'd13,
                                        random_addr(), random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h40, 12'd20, 8'h9C, 4'd13,
                                        own, random_addr()));
    pending_frames.push_back(make_frame(KindMgmt, 8'h80, 12'd20, 8'h9C, 4'd13,
                                        random_addr(), random_addr()));
    wait_idle();

    write_reg(CfgOwnAddress, 48'hFFFFFFFFFFFF);
    run_random(150, 45, 0, 1'b0);

    // zero first byte turns the filter off
    write_reg(CfgOwnAddress, 48'h00FFFFFFFFFF);
    run_random(150, 0, 45, 1'b1);

    write_reg(CfgFilterEnable, 48'd0);
    write_reg(CfgOwnAddress, 48'h123456789ABC);
    run_random(150, 35, 35, 1'b0);

    write_reg(CfgFilterEnable, 48'd1);
    write_reg(CfgOwnAddress, 48'h010000000000);
    run_random(150, 0, 0, 1'b1);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
